@@ sv/tfsal_pkg.sv @@
package tfsal_pkg;

  localparam int DELTA_BITS_DEFAULT = 12;

  localparam int SCALE_W   = 10;
  localparam int FINGERS_W = 4;
  localparam int POINTER_W = 8;
  localparam int OUT_W     = 8;
  localparam int REM_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam int DIVISOR     = 100;
  localparam int SCROLL_MIN_FINGERS = 2;
  localparam int SAT_LIMIT   = 127;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(100);

  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_SCALE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_HORIZONTAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_VERTICAL   = 2'd2;

  typedef logic [1:0] lock_t;

  localparam lock_t LOCK_UNDECIDED  = 2'd0;
  localparam lock_t LOCK_VERTICAL   = 2'd1;
  localparam lock_t LOCK_HORIZONTAL = 2'd2;
  localparam lock_t LOCK_BOTH       = 2'd3;

endpackage

@@ sv/two_finger_scroll_axis_lock_top.sv @@
// Throughput: one transaction per cycle unless out_stall holds the pipeline;
// the delta multiply, the divide by one hundred and the remainder and axis
// lock update each take one pipeline stage.
// Reset (rst, synchronous, active high) clears the pipeline, sets both remainders
// to zero, the axis lock to undecided, and the registers to their reset values.
module two_finger_scroll_axis_lock_top
  import tfsal_pkg::*;
#(
  parameter int DELTA_BITS = DELTA_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [SCALE_W-1:0]           cfg_data,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [FINGERS_W-1:0]         finger_count,
  input  logic signed [DELTA_BITS-1:0] delta_x,
  input  logic signed [DELTA_BITS-1:0] delta_y,
  input  logic signed [DELTA_BITS-1:0] prev_delta_x,
  input  logic signed [DELTA_BITS-1:0] prev_delta_y,
  input  logic signed [POINTER_W-1:0]  pointer_x,
  input  logic signed [POINTER_W-1:0]  pointer_y,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [OUT_W-1:0]      move_x,
  output logic signed [OUT_W-1:0]      move_y,
  output logic signed [OUT_W-1:0]      scroll_v,
  output logic signed [OUT_W-1:0]      scroll_h
);

  localparam int P_W      = DELTA_BITS + SCALE_W + 1;
  localparam int MAG_W    = DELTA_BITS + 9;
  localparam int SH       = MAG_W;
  localparam int RECIP_W  = MAG_W - 6;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SH) / DIVISOR);
  localparam int QM_W     = RECIP_W;
  localparam int Q_W      = QM_W + 1;
  localparam int W_W      = Q_W + 1;

  logic [SCALE_W-1:0] scroll_scale;
  logic               reverse_horizontal;
  logic               reverse_vertical;

  logic signed [REM_W-1:0] remainder_x;
  logic signed [REM_W-1:0] remainder_y;
  lock_t                   axis_lock;

  logic v1, v2, v3;
  logic load1, load2, load3, load_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_scale       <= SCALE_RESET;
      reverse_horizontal <= 1'b0;
      reverse_vertical   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SCROLL_SCALE) begin
        scroll_scale <= cfg_data;
      end
      if (cfg_index == REG_REVERSE_HORIZONTAL) begin
        reverse_horizontal <= cfg_data[0];
      end
      if (cfg_index == REG_REVERSE_VERTICAL) begin
        reverse_vertical <= cfg_data[0];
      end
    end
  end

  assign load_out = !out_valid || !out_stall;
  assign load3    = !v3 || load_out;
  assign load2    = !v2 || load3;
  assign load1    = !v1 || load2;
  assign in_stall = !load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load1) begin
        v1 <= in_valid;
      end
      if (load2) begin
        v2 <= v1;
      end
      if (load3) begin
        v3 <= v2;
      end
      if (load_out) begin
        out_valid <= v3;
      end
    end
  end

  // Stage 1: input register.
  logic                         s1_scroll;
  logic signed [DELTA_BITS-1:0] s1_dx, s1_dy, s1_pdx, s1_pdy;
  logic signed [POINTER_W-1:0]  s1_px, s1_py;

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_scroll <= finger_count >= FINGERS_W'(SCROLL_MIN_FINGERS);
      s1_dx     <= delta_x;
      s1_dy     <= delta_y;
      s1_pdx    <= prev_delta_x;
      s1_pdy    <= prev_delta_y;
      s1_px     <= pointer_x;
      s1_py     <= pointer_y;
    end
  end

  function automatic logic [DELTA_BITS-1:0] dmag(input logic signed [DELTA_BITS-1:0] v);
    logic signed [DELTA_BITS:0] e;
    e = {v[DELTA_BITS-1], v};
    if (e < 0) begin
      e = -e;
    end
    return e[DELTA_BITS-1:0];
  endfunction

  function automatic logic ddom(input logic signed [DELTA_BITS-1:0] a,
                                input logic signed [DELTA_BITS-1:0] b);
    logic [DELTA_BITS:0] ma, mb2;
    ma  = {1'b0, dmag(a)};
    mb2 = {dmag(b), 1'b0};
    return ma > mb2;
  endfunction

  // Stage 2: scaled deltas and axis preference flags.
  logic                        s2_scroll;
  logic signed [P_W-1:0]       s2_px_prod, s2_py_prod;
  logic                        s2_cur_v, s2_cur_h, s2_prev_v, s2_prev_h;
  logic signed [POINTER_W-1:0] s2_px, s2_py;

  logic signed [SCALE_W:0] scale_s;
  assign scale_s = signed'({1'b0, scroll_scale});

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_scroll  <= s1_scroll;
      s2_px_prod <= P_W'(s1_dx) * P_W'(scale_s);
      s2_py_prod <= P_W'(s1_dy) * P_W'(scale_s);
      s2_cur_v   <= ddom(s1_dy, s1_dx);
      s2_cur_h   <= ddom(s1_dx, s1_dy);
      s2_prev_v  <= ddom(s1_pdy, s1_pdx);
      s2_prev_h  <= ddom(s1_pdx, s1_pdy);
      s2_px      <= s1_px;
      s2_py      <= s1_py;
    end
  end

  // Division by one hundred, truncated toward zero, by reciprocal multiply
  // followed by a single correction step.
  typedef struct packed {
    logic signed [Q_W-1:0]   quo;
    logic signed [REM_W-1:0] rem;
  } qr_t;

  function automatic qr_t div100(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0]      pa;
    logic [MAG_W-1:0]           n;
    logic [MAG_W+RECIP_W-1:0]   prod;
    logic [QM_W-1:0]            q0;
    logic [MAG_W-1:0]           r0_full;
    logic [7:0]                 r0;
    logic [QM_W-1:0]            qm;
    logic [REM_W-1:0]           rm;
    qr_t                        res;
    pa      = (p < 0) ? -p : p;
    n       = pa[MAG_W-1:0];
    prod    = (MAG_W+RECIP_W)'(n) * (MAG_W+RECIP_W)'(RECIP);
    q0      = prod[MAG_W+RECIP_W-1:SH];
    r0_full = n - MAG_W'(MAG_W'(q0) * MAG_W'(DIVISOR));
    r0      = r0_full[7:0];
    if (r0 >= 8'(DIVISOR)) begin
      qm = q0 + QM_W'(1);
      rm = r0 - 8'(DIVISOR);
    end else begin
      qm = q0;
      rm = r0;
    end
    if (p < 0) begin
      res.quo = -signed'({1'b0, qm});
      res.rem = -signed'(rm);
    end else begin
      res.quo = signed'({1'b0, qm});
      res.rem = signed'(rm);
    end
    return res;
  endfunction

  // Stage 3: quotient and remainder of each scaled delta.
  logic                        s3_scroll;
  qr_t                         s3_x, s3_y;
  logic                        s3_cur_v, s3_cur_h, s3_prev_v, s3_prev_h;
  logic signed [POINTER_W-1:0] s3_px, s3_py;

  always_ff @(posedge clk) begin
    if (load3) begin
      s3_scroll <= s2_scroll;
      s3_x      <= div100(s2_px_prod);
      s3_y      <= div100(s2_py_prod);
      s3_cur_v  <= s2_cur_v;
      s3_cur_h  <= s2_cur_h;
      s3_prev_v <= s2_prev_v;
      s3_prev_h <= s2_prev_h;
      s3_px     <= s2_px;
      s3_py     <= s2_py;
    end
  end

  // The old remainder is folded in here: the sum of the two remainders is
  // split into a floor quotient and a rest, then adjusted to truncation.
  typedef struct packed {
    logic signed [W_W-1:0]   whole;
    logic signed [REM_W-1:0] rest;
  } acc_t;

  function automatic acc_t fold(input qr_t qr, input logic signed [REM_W-1:0] old_rem);
    logic signed [9:0]     s;
    logic signed [2:0]     c;
    logic signed [9:0]     m_full;
    logic [6:0]            m;
    logic signed [W_W-1:0] f;
    acc_t                  res;
    s = 10'(old_rem) + 10'(qr.rem);
    if (s < -10'sd100) begin
      c      = -3'sd2;
      m_full = s + 10'sd200;
    end else if (s < 10'sd0) begin
      c      = -3'sd1;
      m_full = s + 10'sd100;
    end else if (s < 10'sd100) begin
      c      = 3'sd0;
      m_full = s;
    end else begin
      c      = 3'sd1;
      m_full = s - 10'sd100;
    end
    m = m_full[6:0];
    f = W_W'(qr.quo) + W_W'(c);
    if (f < 0 && m != 7'd0) begin
      res.whole = f + W_W'(1);
      res.rest  = signed'({1'b0, m}) - REM_W'(DIVISOR);
    end else begin
      res.whole = f;
      res.rest  = signed'({1'b0, m});
    end
    return res;
  endfunction

  function automatic logic [W_W-1:0] wmag(input logic signed [W_W-1:0] v);
    logic signed [W_W:0] e;
    e = W_W'(0) + {v[W_W-1], v};
    if (e < 0) begin
      e = -e;
    end
    return e[W_W-1:0];
  endfunction

  function automatic logic wdom(input logic signed [W_W-1:0] a,
                                input logic signed [W_W-1:0] b);
    logic [W_W:0] ma, mb2;
    ma  = {1'b0, wmag(a)};
    mb2 = {wmag(b), 1'b0};
    return ma > mb2;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [W_W-1:0] w,
                                                      input logic rev);
    logic signed [W_W:0] v;
    v = {w[W_W-1], w};
    if (rev) begin
      v = -v;
    end
    if (v > (W_W+1)'(SAT_LIMIT)) begin
      return OUT_W'(SAT_LIMIT);
    end else if (v < -(W_W+1)'(SAT_LIMIT)) begin
      return -OUT_W'(SAT_LIMIT);
    end
    return v[OUT_W-1:0];
  endfunction

  acc_t  acc_x, acc_y;
  lock_t lock_next;
  lock_t lock_kept;
  logic  en_v, en_h;

  assign acc_x = fold(s3_x, remainder_x);
  assign acc_y = fold(s3_y, remainder_y);

  always_comb begin
    lock_kept = axis_lock;
    if (s3_cur_v && s3_prev_v) begin
      if (axis_lock == LOCK_HORIZONTAL) begin
        lock_kept = LOCK_BOTH;
      end
    end else if (s3_cur_h && s3_prev_h) begin
      if (axis_lock == LOCK_VERTICAL) begin
        lock_kept = LOCK_BOTH;
      end
    end

    lock_next = lock_kept;
    en_v      = 1'b0;
    en_h      = 1'b0;
    if (!s3_scroll) begin
      lock_next = LOCK_UNDECIDED;
    end else if (axis_lock == LOCK_UNDECIDED) begin
      if (acc_x.whole != 0 || acc_y.whole != 0) begin
        if (wdom(acc_y.whole, acc_x.whole)) begin
          lock_next = LOCK_VERTICAL;
        end else if (wdom(acc_x.whole, acc_y.whole)) begin
          lock_next = LOCK_HORIZONTAL;
        end else begin
          lock_next = LOCK_BOTH;
        end
      end else begin
        lock_next = LOCK_UNDECIDED;
      end
    end else begin
      en_v = (lock_kept == LOCK_VERTICAL) || (lock_kept == LOCK_BOTH);
      en_h = (lock_kept == LOCK_HORIZONTAL) || (lock_kept == LOCK_BOTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder_x <= '0;
      remainder_y <= '0;
      axis_lock   <= LOCK_UNDECIDED;
    end else if (load_out && v3) begin
      axis_lock <= lock_next;
      if (s3_scroll) begin
        remainder_x <= acc_x.rest;
        remainder_y <= acc_y.rest;
      end
    end
  end

  // Stage 4: result register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      move_x   <= s3_scroll ? '0 : s3_px;
      move_y   <= s3_scroll ? '0 : s3_py;
      scroll_v <= en_v ? sat_out(acc_y.whole, reverse_vertical) : '0;
      scroll_h <= en_h ? sat_out(acc_x.whole, reverse_horizontal) : '0;
    end
  end

endmodule

@@ verif/tb_two_finger_scroll_axis_lock_top.sv @@
`timescale 1ns / 100ps

module tb_two_finger_scroll_axis_lock_top;
  import tfsal_pkg::*;

  localparam int DW = DELTA_BITS_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [FINGERS_W-1:0] fingers;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] pdx;
    logic signed [DW-1:0] pdy;
    logic signed [POINTER_W-1:0] ptr_x;
    logic signed [POINTER_W-1:0] ptr_y;
  } report_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] move_x;
    logic signed [OUT_W-1:0] move_y;
    logic signed [OUT_W-1:0] scroll_v;
    logic signed [OUT_W-1:0] scroll_h;
  } motion_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SCALE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FINGERS_W-1:0] finger_count = '0;
  logic signed [DW-1:0] delta_x = '0;
  logic signed [DW-1:0] delta_y = '0;
  logic signed [DW-1:0] prev_delta_x = '0;
  logic signed [DW-1:0] prev_delta_y = '0;
  logic signed [POINTER_W-1:0] pointer_x = '0;
  logic signed [POINTER_W-1:0] pointer_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] move_x;
  logic signed [OUT_W-1:0] move_y;
  logic signed [OUT_W-1:0] scroll_v;
  logic signed [OUT_W-1:0] scroll_h;

  two_finger_scroll_axis_lock_top #(.DELTA_BITS(DW)) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .finger_count(finger_count),
    .delta_x(delta_x), .delta_y(delta_y), .prev_delta_x(prev_delta_x),
    .prev_delta_y(prev_delta_y), .pointer_x(pointer_x), .pointer_y(pointer_y),
    .out_valid(out_valid), .out_stall(out_stall), .move_x(move_x), .move_y(move_y),
    .scroll_v(scroll_v), .scroll_h(scroll_h)
  );

  always #1 clk = ~clk;

  report_t report_q[$];
  motion_t expected_motion[$];

  logic [SCALE_W-1:0] gain_pct = SCALE_RESET;
  logic flip_h = 1'b0;
  logic flip_v = 1'b0;
  int rem_x = 0;
  int rem_y = 0;
  lock_t lock = LOCK_UNDECIDED;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit in_taken = 1'b0;
  int errors = 0;
  int checked = 0;
  int scroll_reports = 0;
  int wheel_results = 0;
  int settings = 1;
  int queued = 0;
  int cycles = 0;

  function automatic bit over_twice(int a, int b);
    return (a < 0 ? -a : a) > 2 * (b < 0 ? -b : b);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_wheel(int v);
    if (v > SAT_LIMIT) v = SAT_LIMIT;
    else if (v < -SAT_LIMIT) v = -SAT_LIMIT;
    return OUT_W'(v);
  endfunction

  function automatic motion_t predict_motion(report_t r);
    motion_t m;
    int dxi, dyi, pdxi, pdyi, ax, ay, wx, wy;
    m = '0;
    dxi = r.dx;
    dyi = r.dy;
    pdxi = r.pdx;
    pdyi = r.pdy;
    if (r.fingers >= SCROLL_MIN_FINGERS) begin
      scroll_reports++;
      ax = rem_x + dxi * int'(gain_pct);
      ay = rem_y + dyi * int'(gain_pct);
      wx = ax / DIVISOR;
      wy = ay / DIVISOR;
      rem_x = ax - wx * DIVISOR;
      rem_y = ay - wy * DIVISOR;
      if (lock == LOCK_UNDECIDED) begin
        if (wx != 0 || wy != 0) begin
          if (over_twice(wy, wx)) lock = LOCK_VERTICAL;
          else if (over_twice(wx, wy)) lock = LOCK_HORIZONTAL;
          else lock = LOCK_BOTH;
        end
      end else begin
        if (over_twice(dyi, dxi) && over_twice(pdyi, pdxi)) begin
          if (lock == LOCK_HORIZONTAL) lock = LOCK_BOTH;
        end else if (over_twice(dxi, dyi) && over_twice(pdxi, pdyi)) begin
          if (lock == LOCK_VERTICAL) lock = LOCK_BOTH;
        end
        if (lock == LOCK_VERTICAL || lock == LOCK_BOTH)
          m.scroll_v = clamp_wheel(flip_v ? -wy : wy);
        if (lock == LOCK_HORIZONTAL || lock == LOCK_BOTH)
          m.scroll_h = clamp_wheel(flip_h ? -wx : wx);
        if (m.scroll_v != 0 || m.scroll_h != 0) wheel_results++;
      end
    end else begin
      lock = LOCK_UNDECIDED;
      m.move_x = r.ptr_x;
      m.move_y = r.ptr_y;
    end
    return m;
  endfunction

  task automatic log_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Sample both channels on the rising edge; predict first so that a result taken
  // in the same cycle as its input would still find its expectation.
  always @(posedge clk) begin : monitor
    report_t r;
    motion_t got, want;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        r.fingers = finger_count;
        r.dx = delta_x;
        r.dy = delta_y;
        r.pdx = prev_delta_x;
        r.pdy = prev_delta_y;
        r.ptr_x = pointer_x;
        r.ptr_y = pointer_y;
        expected_motion.push_back(predict_motion(r));
      end
      if (out_valid && !out_stall) begin
        got = '{move_x, move_y, scroll_v, scroll_h};
        if (expected_motion.size() == 0) begin
          log_error($sformatf("unexpected result move=(%0d,%0d) scroll v=%0d h=%0d",
                              move_x, move_y, scroll_v, scroll_h));
        end else begin
          want = expected_motion.pop_front();
          checked++;
          if (got !== want)
            log_error($sformatf({"result %0d: move_x %0d/%0d move_y %0d/%0d ",
                                 "scroll_v %0d/%0d scroll_h %0d/%0d (expected/actual)"},
                                checked, want.move_x, got.move_x, want.move_y, got.move_y,
                                want.scroll_v, got.scroll_v, want.scroll_h, got.scroll_h));
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    report_t nxt;
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (report_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = report_q.pop_front();
          in_valid <= 1'b1;
          finger_count <= nxt.fingers;
          delta_x <= nxt.dx;
          delta_y <= nxt.dy;
          prev_delta_x <= nxt.pdx;
          prev_delta_y <= nxt.pdy;
          pointer_x <= nxt.ptr_x;
          pointer_y <= nxt.ptr_y;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               expected_motion.size());
      $display("tb_two_finger_scroll_axis_lock_top: done, errors");
      $finish;
    end
  end

  task automatic push_report(int f, int dx, int dy, int pdx, int pdy, int px, int py);
    report_t r;
    r.fingers = FINGERS_W'(f);
    r.dx = DW'(dx);
    r.dy = DW'(dy);
    r.pdx = DW'(pdx);
    r.pdy = DW'(pdy);
    r.ptr_x = POINTER_W'(px);
    r.ptr_y = POINTER_W'(py);
    report_q.push_back(r);
    queued++;
  endtask

  task automatic push_noise();
    push_report($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // A lift to zero or one finger, then a run of reports with two or more fingers
  // whose previous deltas chain correctly; the style picks which axis dominates.
  task automatic push_gesture();
    int len, style, major, minor, cx, cy, px, py, sgn_a, sgn_b;
    bit vert;
    len = $urandom_range(3, 14);
    style = $urandom_range(3);
    sgn_a = $urandom_range(1) ? 1 : -1;
    sgn_b = $urandom_range(1) ? 1 : -1;
    px = $urandom_range(40) - 20;
    py = $urandom_range(40) - 20;
    push_report($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < len; i++) begin
      major = $urandom_range(1, 60);
      minor = (style == 2) ? $urandom_range(major / 2, major) : $urandom_range(major / 3);
      if ($urandom_range(19) == 0) begin
        major = (sgn_a > 0) ? 2047 : 2048;
        minor = $urandom_range(2047);
      end
      if ($urandom_range(9) == 0) sgn_a = -sgn_a;
      vert = (style == 0) || (style == 3 && i >= len / 2) || (style == 2 && i[0]);
      if (vert) begin
        cy = sgn_a * major;
        cx = sgn_b * minor;
      end else begin
        cx = sgn_a * major;
        cy = sgn_b * minor;
      end
      push_report(($urandom_range(7) == 0) ? $urandom_range(2, 15) : 2, cx, cy, px, py,
                  $urandom, $urandom);
      px = cx;
      py = cy;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCROLL_SCALE: gain_pct = data;
      REG_REVERSE_HORIZONTAL: flip_h = data[0];
      REG_REVERSE_VERTICAL: flip_v = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int scale, bit rh, bit rv);
    write_reg(REG_SCROLL_SCALE, SCALE_W'(scale));
    write_reg(REG_REVERSE_HORIZONTAL, {(SCALE_W-1)'($urandom), rh});
    write_reg(REG_REVERSE_VERTICAL, {(SCALE_W-1)'($urandom), rv});
    write_reg(REG_UNUSED, SCALE_W'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic drain();
    do @(posedge clk); while (report_q.size() != 0 || in_valid || expected_motion.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int n, int s_idle, int r_stall);
    int target;
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    target = queued + n;
    @(posedge clk);
    while (queued < target) begin
      if ($urandom_range(9) < 8) push_gesture();
      else push_noise();
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 32;
    recv_stall_pct = 61;
    @(posedge clk);
    push_report(1, 0, 0, 0, 0, 127, -127);
    push_report(0, 2047, -2048, 2047, -2048, -128, 0);
    push_report(2, 0, 0, 0, 0, 5, 5);
    push_report(2, 1, 5, 0, 0, 7, 7);
    push_report(2, 1, 4, 1, 5, 0, 0);
    push_report(2, 6, 1, 1, 4, 0, 0);
    push_report(2, 6, 1, 6, 1, 0, 0);
    push_report(15, 2047, -2048, 2047, -2048, 1, 1);
    push_report(1, 3, 3, 3, 3, -1, 1);
    push_report(2, -9, 2, 0, 0, 0, 0);
    push_report(3, -9, 1, -9, 2, 0, 0);
    push_report(2, 1, 9, 1, 9, 0, 0);
    push_report(0, 0, 0, 0, 0, 0, 0);
    push_report(2, 3, 3, 0, 0, 0, 0);
    push_report(2, -2048, 2047, 3, 3, 0, 0);
    push_report(4, 0, 0, -2048, 2047, 0, 0);
    push_report(1, 0, 0, 0, 0, 0, 0);
    push_report(2, 2047, 0, 0, 0, 0, 0);
    push_report(2, 0, 2047, 0, 2047, 0, 0);
    drain();

    run_random(90, 32, 61);
    set_config(37, 1'b1, 1'b0);
    run_random(90, 32, 61);
    set_config(1000, 1'b0, 1'b1);
    run_random(90, 61, 32);
    set_config(1023, 1'b1, 1'b1);
    run_random(90, 61, 32);
    set_config(0, 1'b0, 1'b0);
    run_random(40, 0, 0);
    set_config(1, 1'b1, 1'b1);
    run_random(50, 0, 0);
    set_config($urandom_range(2, 999), $urandom_range(1), $urandom_range(1));
    run_random(90, 0, 0);

    errors += expected_motion.size();
    $display("Checked %0d results from %0d reports (%0d in scroll mode, %0d with wheel steps).",
             checked, queued, scroll_reports, wheel_results);
    $display("Register settings used: %0d, scale from 0 to 1023, both reverse flags; %0d errors.",
             settings, errors);
    if (errors == 0) begin
      $display("tb_two_finger_scroll_axis_lock_top: done, clean");
    end else begin
      $display("tb_two_finger_scroll_axis_lock_top: done, errors");
    end
    $finish;
  end

endmodule
